[rtl/core/prsa_pkg.sv]
// Shared types and constants for the protection region slot allocator.
package prsa_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int ACT_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [31:0] ADDR_ONES = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_SLOTS = 2'd0,
    CFG_FIRST_REGION = 2'd1,
    CFG_FREE_CODE    = 2'd2,
    CFG_RELEASE_CODE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  req_domain;
    logic [31:0] req_start;
    logic [31:0] req_end;
    logic [31:0] read_mask;
    logic [31:0] write_mask;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        released;
    logic [7:0]  region_number;
    logic [31:0] region_start;
    logic [31:0] region_end;
    logic [7:0]  region_owner;
    logic [31:0] read_perm;
    logic [31:0] write_perm;
  } res_t;

  typedef struct packed {
    logic [31:0] addr_lo;
    logic [31:0] addr_hi;
    logic [7:0]  owner;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);
  localparam slot_t SLOT_RESET = '{addr_lo: ADDR_ONES, addr_hi: ADDR_ONES, owner: 8'h00};

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic scan_empty;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/prsa_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module prsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/prsa_ctrl.sv]
// Controller state machine that sequences the slot scan and the final update.
module prsa_ctrl
  import prsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = stat.scan_empty ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/prsa_dp.sv]
// Datapath with configuration, slot table, scan compare logic and result register.
module prsa_dp
  import prsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output res_t                  out_item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat
);

  logic [ACT_W-1:0] active_slots;
  logic [7:0]       first_region;
  logic [7:0]       free_code;
  logic [7:0]       release_code;

  req_t             req_q;
  logic [IDX_W-1:0] idx;
  logic             eval_en;
  logic [IDX_W-1:0] eval_idx;
  logic             valid_q;
  logic [MAX_SLOTS-1:0] slot_valid;
  logic             has_match;
  logic             has_free;
  logic [IDX_W-1:0] pick;

  logic [SLOT_W-1:0] ram_rdata;
  slot_t            entry;
  slot_t            wr_entry;
  logic             hit_match;
  logic             hit_free;
  logic             found;
  logic             do_release;
  logic [CNT_W-1:0] scan_count;
  res_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= ACT_W'(16);
      first_region <= 8'd0;
      free_code <= 8'd0;
      release_code <= 8'd1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ACTIVE_SLOTS: active_slots <= cfg_data[ACT_W-1:0];
        CFG_FIRST_REGION: first_region <= cfg_data;
        CFG_FREE_CODE:    free_code <= cfg_data;
        CFG_RELEASE_CODE: release_code <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (32'(active_slots) > 32'(MAX_SLOTS)) begin
      scan_count = CNT_W'(MAX_SLOTS);
    end else begin
      scan_count = CNT_W'(active_slots);
    end
  end

  assign stat.scan_empty = (scan_count == '0);
  assign stat.scan_last = ((CNT_W'(idx) + CNT_W'(1)) == scan_count);
  assign stat.out_free = !out_valid || !out_stall;

  assign entry = valid_q ? slot_t'(ram_rdata) : SLOT_RESET;
  assign hit_match = (entry.addr_lo == req_q.req_start) && (entry.addr_hi == req_q.req_end);
  assign hit_free = (entry.owner == free_code) && (entry.addr_lo == ADDR_ONES) &&
                    (entry.addr_hi == ADDR_ONES);

  assign found = has_match || has_free;
  assign do_release = has_match && (req_q.req_domain == release_code);

  always_comb begin
    if (do_release) begin
      wr_entry = '{addr_lo: ADDR_ONES, addr_hi: ADDR_ONES, owner: free_code};
    end else begin
      wr_entry = '{addr_lo: req_q.req_start, addr_hi: req_q.req_end, owner: req_q.req_domain};
    end
    res = '0;
    if (found) begin
      res.released = do_release;
      res.region_number = first_region + 8'(pick);
      res.region_start = wr_entry.addr_lo;
      res.region_end = wr_entry.addr_hi;
      res.region_owner = wr_entry.owner;
      res.read_perm = req_q.read_mask;
      res.write_perm = req_q.write_mask;
    end else begin
      res.status = 1'b1;
    end
  end

  prsa_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(MAX_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (cmd.commit && found),
    .waddr(pick),
    .wdata(wr_entry),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      eval_en <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      eval_en <= cmd.step;
      if (cmd.commit && found) begin
        slot_valid[pick] <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    valid_q <= slot_valid[idx];
    eval_idx <= idx;
    if (cmd.load) begin
      req_q <= in_item;
      idx <= '0;
      has_match <= 1'b0;
      has_free <= 1'b0;
      pick <= '0;
    end else begin
      if (cmd.step) begin
        idx <= idx + IDX_W'(1);
      end
      if (eval_en && !has_match) begin
        if (hit_match) begin
          has_match <= 1'b1;
          pick <= eval_idx;
        end else if (!has_free && hit_free) begin
          has_free <= 1'b1;
          pick <= eval_idx;
        end
      end
    end
    if (cmd.commit) begin
      out_item <= res;
    end
  end

endmodule

[rtl/core/protection_region_slot_allocator.sv]
// An accepted item is compared against the first min(active_slots, 16) slots, one slot read
// and compared per cycle, then committed to the output register once it is free; with no
// active slot the scan is skipped. Input is stalled until the commit, so a new item is taken
// only after the last result is committed, and may be taken while that result still waits.
// Reset clears control state and slot valid bits and loads the default configuration, so every
// slot reads as invalid addresses with owner zero until written.
module protection_region_slot_allocator
  import prsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  req_t                  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output res_t                  out_item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  prsa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  prsa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) cmd.commit |-> !(out_valid && out_stall))
    else $error("Result committed over a stalled item.");
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(cmd.commit))
    else $error("Output became valid without a commit.");
  assert property (@(posedge clk) disable iff (rst) cmd.step |-> !stat.scan_empty)
    else $error("Scan step issued with no active slots.");
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> in_stall)
    else $error("Input not stalled after an item was accepted.");
`endif

endmodule
